>>> hw/rtl/rwhp_pkg.sv
// Shared types and constants for the RIFF/WAVE header parser.
package rwhp_pkg;

  localparam int RWHP_OFFSET_WIDTH = 32;
  localparam int RWHP_QUEUE_DEPTH  = 4;

  // Tags as they appear on the wire, first byte in the low bits
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_MIN_LEN = 32'd16;

  localparam logic [15:0] CODE_PCM   = 16'd1;
  localparam logic [15:0] CODE_FLOAT = 16'd3;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD    = 2'd1,
    ST_UNSUPP = 2'd2
  } status_t;

  localparam logic [1:0] FMT_TAG_NONE  = 2'd0;
  localparam logic [1:0] FMT_TAG_PCM   = 2'd1;
  localparam logic [1:0] FMT_TAG_FLOAT = 2'd3;

  // Parser state handed to the result unit on the final byte
  typedef struct packed {
    logic        riff_done;
    logic        hdr_ok;
    logic        have_fmt;
    logic        have_data;
    logic [15:0] code;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] pos;
    logic [31:0] start;
    logic [31:0] declared;
  } snap_t;

endpackage

>>> hw/rtl/rwhp_front.sv
// Input queue: accepts image bytes and holds them for the parser.
module rwhp_front
  import rwhp_pkg::*;
#(
  parameter int DEPTH = RWHP_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       q_valid,
  output logic [7:0] q_byte,
  output logic       q_last,
  input  logic       q_pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [8:0]    entry_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign in_ready = (count_r != CW'(DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_byte   = entry_r[rd_ptr_r][7:0];
  assign q_last   = entry_r[rd_ptr_r][8];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= {in_last_byte, in_data_byte};
    end
  end

endmodule

>>> hw/rtl/rwhp_parse.sv
// Chunk walker: checks the RIFF/WAVE tags and tracks fmt and data chunks.
module rwhp_parse
  import rwhp_pkg::*;
#(
  parameter int OFFSET_WIDTH = RWHP_OFFSET_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  logic [7:0] q_byte,
  input  logic       q_last,
  output logic       q_pop,
  input  logic       emit_idle,
  output logic       snap_valid,
  output snap_t      snap
);

  typedef enum logic [3:0] {
    PH_RIFF = 4'b0001,
    PH_HDR  = 4'b0010,
    PH_BODY = 4'b0100,
    PH_PAD  = 4'b1000
  } phase_t;

  localparam int OW = OFFSET_WIDTH;

  phase_t        phase_r, phase_nxt;
  logic [OW-1:0] pos_r, pos_nxt;
  logic          hdr_ok_r, hdr_ok_nxt;
  logic [2:0]    hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]   tag_r, tag_nxt;
  logic [31:0]   len_r, len_nxt;
  logic [31:0]   remain_r, remain_nxt;
  logic          pad_r, pad_nxt;
  logic          fmt_body_r, fmt_body_nxt;
  logic [4:0]    fmt_idx_r, fmt_idx_nxt;
  logic [15:0]   code_scr_r, code_scr_nxt;
  logic [15:0]   ch_scr_r, ch_scr_nxt;
  logic [31:0]   rate_scr_r, rate_scr_nxt;
  logic [15:0]   bits_scr_r, bits_scr_nxt;
  logic [15:0]   code_com_r, code_com_nxt;
  logic [15:0]   ch_com_r, ch_com_nxt;
  logic [31:0]   rate_com_r, rate_com_nxt;
  logic [15:0]   bits_com_r, bits_com_nxt;
  logic          have_fmt_r, have_fmt_nxt;
  logic          have_data_r, have_data_nxt;
  logic [OW-1:0] start_r, start_nxt;
  logic [31:0]   declared_r, declared_nxt;
  logic          take;
  logic [3:0]    idx;

  // Hold a final byte until the result unit is free
  assign take       = q_valid && (!q_last || emit_idle);
  assign q_pop      = take;
  assign snap_valid = take && q_last;
  assign idx        = fmt_idx_r[3:0];

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r + 1'b1;
    hdr_ok_nxt    = hdr_ok_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    tag_nxt       = tag_r;
    len_nxt       = len_r;
    remain_nxt    = remain_r;
    pad_nxt       = pad_r;
    fmt_body_nxt  = fmt_body_r;
    fmt_idx_nxt   = fmt_idx_r;
    code_scr_nxt  = code_scr_r;
    ch_scr_nxt    = ch_scr_r;
    rate_scr_nxt  = rate_scr_r;
    bits_scr_nxt  = bits_scr_r;
    code_com_nxt  = code_com_r;
    ch_com_nxt    = ch_com_r;
    rate_com_nxt  = rate_com_r;
    bits_com_nxt  = bits_com_r;
    have_fmt_nxt  = have_fmt_r;
    have_data_nxt = have_data_r;
    start_nxt     = start_r;
    declared_nxt  = declared_r;

    unique case (phase_r)
      PH_RIFF: begin
        if (pos_r < OW'(4)) begin
          if (q_byte != TAG_RIFF[{pos_r[1:0], 3'b000} +: 8]) hdr_ok_nxt = 1'b0;
        end else if (pos_r >= OW'(8) && pos_r < OW'(12)) begin
          if (q_byte != TAG_WAVE[{pos_r[1:0], 3'b000} +: 8]) hdr_ok_nxt = 1'b0;
        end
        if (pos_r >= OW'(11)) begin
          phase_nxt   = PH_HDR;
          hdr_cnt_nxt = '0;
        end
      end
      PH_HDR: begin
        if (!hdr_cnt_r[2]) begin
          tag_nxt = {q_byte, tag_r[31:8]};
        end else begin
          len_nxt = {q_byte, len_r[31:8]};
        end
        hdr_cnt_nxt = hdr_cnt_r + 1'b1;
        if (hdr_cnt_r == 3'd7) begin
          fmt_body_nxt = (tag_nxt == TAG_FMT) && (len_nxt >= FMT_MIN_LEN);
          fmt_idx_nxt  = '0;
          if (tag_nxt == TAG_DATA) begin
            start_nxt     = pos_nxt;
            declared_nxt  = len_nxt;
            have_data_nxt = 1'b1;
          end
          remain_nxt = len_nxt;
          pad_nxt    = len_nxt[0];
          phase_nxt  = (len_nxt == '0) ? PH_HDR : PH_BODY;
        end
      end
      PH_BODY: begin
        if (fmt_body_r && !fmt_idx_r[4]) begin
          unique case (idx) inside
            4'd0, 4'd1:             code_scr_nxt[{idx[0], 3'b000} +: 8] = q_byte;
            4'd2, 4'd3:             ch_scr_nxt[{idx[0], 3'b000} +: 8] = q_byte;
            4'd4, 4'd5, 4'd6, 4'd7: rate_scr_nxt[{idx[1:0], 3'b000} +: 8] = q_byte;
            4'd14, 4'd15:           bits_scr_nxt[{idx[0], 3'b000} +: 8] = q_byte;
            default:                code_scr_nxt = code_scr_r;
          endcase
          // Commit once the sixteenth body byte is in
          if (idx == 4'd15) begin
            code_com_nxt = code_scr_nxt;
            ch_com_nxt   = ch_scr_nxt;
            rate_com_nxt = rate_scr_nxt;
            bits_com_nxt = bits_scr_nxt;
            have_fmt_nxt = 1'b1;
          end
          fmt_idx_nxt = fmt_idx_r + 1'b1;
        end
        remain_nxt = remain_r - 1'b1;
        if (remain_r == 32'd1) begin
          phase_nxt = pad_r ? PH_PAD : PH_HDR;
        end
      end
      PH_PAD: begin
        pad_nxt   = 1'b0;
        phase_nxt = PH_HDR;
      end
      default: phase_nxt = PH_RIFF;
    endcase
  end

  always_comb begin
    snap.riff_done = (phase_nxt != PH_RIFF);
    snap.hdr_ok    = hdr_ok_nxt;
    snap.have_fmt  = have_fmt_nxt;
    snap.have_data = have_data_nxt;
    snap.code      = code_com_nxt;
    snap.channels  = ch_com_nxt;
    snap.rate      = rate_com_nxt;
    snap.bits      = bits_com_nxt;
    snap.pos       = 32'(pos_nxt);
    snap.start     = 32'(start_nxt);
    snap.declared  = declared_nxt;
  end

  // The final byte returns everything to the reset state
  always_ff @(posedge clk) begin
    if (!rst_n || snap_valid) begin
      phase_r     <= PH_RIFF;
      pos_r       <= '0;
      hdr_ok_r    <= 1'b1;
      hdr_cnt_r   <= '0;
      tag_r       <= '0;
      len_r       <= '0;
      remain_r    <= '0;
      pad_r       <= 1'b0;
      fmt_body_r  <= 1'b0;
      fmt_idx_r   <= '0;
      code_scr_r  <= '0;
      ch_scr_r    <= '0;
      rate_scr_r  <= '0;
      bits_scr_r  <= '0;
      code_com_r  <= '0;
      ch_com_r    <= '0;
      rate_com_r  <= '0;
      bits_com_r  <= '0;
      have_fmt_r  <= 1'b0;
      have_data_r <= 1'b0;
      start_r     <= '0;
      declared_r  <= '0;
    end else if (take) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      hdr_ok_r    <= hdr_ok_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      tag_r       <= tag_nxt;
      len_r       <= len_nxt;
      remain_r    <= remain_nxt;
      pad_r       <= pad_nxt;
      fmt_body_r  <= fmt_body_nxt;
      fmt_idx_r   <= fmt_idx_nxt;
      code_scr_r  <= code_scr_nxt;
      ch_scr_r    <= ch_scr_nxt;
      rate_scr_r  <= rate_scr_nxt;
      bits_scr_r  <= bits_scr_nxt;
      code_com_r  <= code_com_nxt;
      ch_com_r    <= ch_com_nxt;
      rate_com_r  <= rate_com_nxt;
      bits_com_r  <= bits_com_nxt;
      have_fmt_r  <= have_fmt_nxt;
      have_data_r <= have_data_nxt;
      start_r     <= start_nxt;
      declared_r  <= declared_nxt;
    end
  end

endmodule

>>> hw/rtl/rwhp_emit.sv
// Result unit: validates the captured format and builds the output transfer.
module rwhp_emit
  import rwhp_pkg::*;
#(
  parameter int OFFSET_WIDTH = RWHP_OFFSET_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        snap_valid,
  input  snap_t       snap,
  output logic        emit_idle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [1:0]  out_format_tag,
  output logic [15:0] out_channels,
  output logic [31:0] out_sample_rate,
  output logic [15:0] out_bits_per_sample,
  output logic [15:0] out_block_align,
  output logic [31:0] out_byte_rate,
  output logic [31:0] out_data_offset,
  output logic [31:0] out_data_length
);

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_CALC = 4'b0010,
    E_RATE = 4'b0100,
    E_OUT  = 4'b1000
  } estate_t;

  localparam int OW = OFFSET_WIDTH;

  estate_t       state_r, state_nxt;
  snap_t         snap_r;
  logic          bad_r;
  logic [1:0]    tag_r;
  logic [15:0]   align_r;
  logic [31:0]   len_r;
  logic          bad_c;
  logic [1:0]    tag_c;
  logic [15:0]   align_c;
  logic [OW-1:0] avail_ow;
  logic [31:0]   avail;
  logic [31:0]   len_c;
  logic [31:0]   byte_rate_c;
  status_t       status_c;

  logic [1:0]    status_r;
  logic [1:0]    fmt_tag_r;
  logic [15:0]   ch_r;
  logic [31:0]   rate_r;
  logic [15:0]   bits_r;
  logic [15:0]   out_align_r;
  logic [31:0]   byte_rate_r;
  logic [31:0]   offset_r;
  logic [31:0]   length_r;

  assign emit_idle = (state_r == E_IDLE);
  assign out_valid = (state_r == E_OUT);

  always_comb begin
    bad_c = !snap_r.riff_done || !snap_r.hdr_ok || !snap_r.have_fmt ||
            !snap_r.have_data || (snap_r.channels == '0) || (snap_r.rate == '0);
    tag_c = FMT_TAG_NONE;
    if (snap_r.code == CODE_PCM &&
        (snap_r.bits == 16'd8 || snap_r.bits == 16'd16 ||
         snap_r.bits == 16'd24 || snap_r.bits == 16'd32)) begin
      tag_c = FMT_TAG_PCM;
    end else if (snap_r.code == CODE_FLOAT && snap_r.bits == 16'd32) begin
      tag_c = FMT_TAG_FLOAT;
    end
    align_c  = 16'(snap_r.channels * (snap_r.bits >> 3));
    avail_ow = snap_r.pos[OW-1:0] - snap_r.start[OW-1:0];
    avail    = 32'(avail_ow);
    len_c    = (snap_r.declared > avail) ? avail : snap_r.declared;
  end

  always_comb begin
    byte_rate_c = 32'(snap_r.rate * align_r);
    if (bad_r) begin
      status_c = ST_BAD;
    end else if (tag_r == FMT_TAG_NONE) begin
      status_c = ST_UNSUPP;
    end else if (align_r == '0) begin
      status_c = ST_BAD;
    end else begin
      status_c = ST_OK;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      E_IDLE:  if (snap_valid) state_nxt = E_CALC;
      E_CALC:  state_nxt = E_RATE;
      E_RATE:  state_nxt = E_OUT;
      E_OUT:   if (out_ready) state_nxt = E_IDLE;
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == E_IDLE && snap_valid) begin
      snap_r <= snap;
    end
    if (state_r == E_CALC) begin
      bad_r   <= bad_c;
      tag_r   <= tag_c;
      align_r <= align_c;
      len_r   <= len_c;
    end
    // Zero every field but status when the image is rejected
    if (state_r == E_RATE) begin
      status_r <= status_c;
      if (status_c == ST_OK) begin
        fmt_tag_r   <= tag_r;
        ch_r        <= snap_r.channels;
        rate_r      <= snap_r.rate;
        bits_r      <= snap_r.bits;
        out_align_r <= align_r;
        byte_rate_r <= byte_rate_c;
        offset_r    <= snap_r.start;
        length_r    <= len_r;
      end else begin
        fmt_tag_r   <= FMT_TAG_NONE;
        ch_r        <= '0;
        rate_r      <= '0;
        bits_r      <= '0;
        out_align_r <= '0;
        byte_rate_r <= '0;
        offset_r    <= '0;
        length_r    <= '0;
      end
    end
  end

  assign out_status          = status_r;
  assign out_format_tag      = fmt_tag_r;
  assign out_channels        = ch_r;
  assign out_sample_rate     = rate_r;
  assign out_bits_per_sample = bits_r;
  assign out_block_align     = out_align_r;
  assign out_byte_rate       = byte_rate_r;
  assign out_data_offset     = offset_r;
  assign out_data_length     = length_r;

endmodule

>>> hw/rtl/riff_wav_header_parser_unit.sv
// RIFF/WAVE header parser: streams image bytes in, reports the format after the last byte.
//
// Input channel: one image byte per transfer (in_data_byte), in file order, with
// in_last_byte set on the final byte. A four-entry queue takes bytes at one per
// cycle while not full; the chunk walker drains it at one byte per cycle except
// when it holds a final byte (below), so a steady stream runs at one byte per cycle.
// Result channel: one transfer per image, issued after the final byte. Once the final
// byte leaves the queue, its snapshot is registered, then the status checks, block
// align multiply and length clamp are registered, then the byte rate multiply; the
// output register then holds the result on out_* until out_ready.
// While a result waits, the queue still fills; the walker holds a second final
// byte until the pending result is taken, and ordinary bytes keep flowing.
// Rejected images report status only, with every other field zero.
// Reset (rst_n low, synchronous) empties the queue, drops any pending result and
// returns the walker to expect the RIFF tag at position zero. After each final
// byte the walker also returns to that state on its own.
// Byte positions count modulo 2^OFFSET_WIDTH.
module riff_wav_header_parser_unit
  import rwhp_pkg::*;
#(
  parameter int OFFSET_WIDTH = RWHP_OFFSET_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [1:0]  out_format_tag,
  output logic [15:0] out_channels,
  output logic [31:0] out_sample_rate,
  output logic [15:0] out_bits_per_sample,
  output logic [15:0] out_block_align,
  output logic [31:0] out_byte_rate,
  output logic [31:0] out_data_offset,
  output logic [31:0] out_data_length
);

  logic       q_valid;
  logic [7:0] q_byte;
  logic       q_last;
  logic       q_pop;
  logic       emit_idle;
  logic       snap_valid;
  snap_t      snap;

  rwhp_front #(
    .DEPTH(RWHP_QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_valid      (q_valid),
    .q_byte       (q_byte),
    .q_last       (q_last),
    .q_pop        (q_pop)
  );

  rwhp_parse #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_byte     (q_byte),
    .q_last     (q_last),
    .q_pop      (q_pop),
    .emit_idle  (emit_idle),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  rwhp_emit #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_emit (
    .clk                 (clk),
    .rst_n               (rst_n),
    .snap_valid          (snap_valid),
    .snap                (snap),
    .emit_idle           (emit_idle),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_format_tag      (out_format_tag),
    .out_channels        (out_channels),
    .out_sample_rate     (out_sample_rate),
    .out_bits_per_sample (out_bits_per_sample),
    .out_block_align     (out_block_align),
    .out_byte_rate       (out_byte_rate),
    .out_data_offset     (out_data_offset),
    .out_data_length     (out_data_length)
  );

endmodule

>>> hw/rtl/rwhp_checker.sv
// Port-level checks for the header parser, bound to the top level.
module rwhp_checker
  import rwhp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_data_byte,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [1:0]  out_format_tag,
  input logic [15:0] out_channels,
  input logic [31:0] out_sample_rate,
  input logic [15:0] out_bits_per_sample,
  input logic [15:0] out_block_align,
  input logic [31:0] out_byte_rate,
  input logic [31:0] out_data_offset,
  input logic [31:0] out_data_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_data_length) && $stable(out_byte_rate))
    else $error("result changed while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_format_tag == FMT_TAG_NONE &&
      out_channels == '0 && out_sample_rate == '0 && out_block_align == '0 &&
      out_byte_rate == '0 && out_data_offset == '0 && out_data_length == '0)
    else $error("rejected image carries nonzero fields");

  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |->
      (out_format_tag == FMT_TAG_PCM || out_format_tag == FMT_TAG_FLOAT) &&
      out_channels != '0 && out_sample_rate != '0 && out_block_align != '0)
    else $error("accepted format fails its own checks");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("result repeated after transfer");

endmodule

bind riff_wav_header_parser_unit rwhp_checker u_rwhp_checker (.*);
